// File: rtl/tcs_pkg.sv
package tcs_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;

  // Field widths of the channels.
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;

  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCROLL,
    ST_DONE
  } tcs_state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(32'(row) * COLUMNS + 32'(col));
  endfunction

endpackage

// File: rtl/text_console_scroller.sv
// Character-cell text console with a ROWS by COLUMNS screen store held in one
// single-port-write, registered-read RAM, plus a cursor. Each input beat gives
// exactly one result beat carrying the cursor after the operation and, for a
// read, the byte in the requested cell. A put that does not move past the
// bottom row, a read and an unused opcode each do any RAM access and cursor
// update when accepted, then load the result register.
// Moving past the bottom row scrolls the screen: the RAM is copied up one row,
// one cell a cycle, then the bottom row is filled with spaces. Clear sweeps
// spaces over the whole RAM. After reset the block runs the same clearing pass
// before it accepts its first beat. A new beat is accepted while the previous
// result still waits on the output.
module text_console_scroller (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcs_pkg::OP_W-1:0]     in_opcode,
  input  logic [tcs_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcs_pkg::ROW_W-1:0]    in_read_row,
  input  logic [tcs_pkg::COL_W-1:0]    in_read_column,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcs_pkg::CHAR_W-1:0]   out_cell_char,
  output logic [tcs_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [tcs_pkg::COL_W-1:0]    out_cursor_column
);
  import tcs_pkg::*;

  localparam logic [ADDR_W-1:0] COPY_LEN  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  // Screen RAM.
  logic [CHAR_W-1:0] mem [CELLS];
  logic [CHAR_W-1:0] rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  tcs_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] scan_r, scan_nxt;
  logic [ROW_W-1:0]  cur_y_r, cur_y_nxt;
  logic [COL_W-1:0]  cur_x_r, cur_x_nxt;
  // The reset clearing pass gives no result; a clear or a scroll does.
  logic              reply_r, reply_nxt;
  logic              is_read_r, is_read_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_cell_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;

  logic in_accept;
  logic out_load;
  logic is_newline;
  logic read_in_range;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_accept     = in_valid && in_ready;
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign is_newline    = (in_char_code == NEWLINE_CHAR);
  assign read_in_range = (32'(in_read_row) < ROWS) && (32'(in_read_column) < COLUMNS);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (scan_r == LAST_CELL) begin
          state_nxt = reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          priority case (in_opcode)
            OP_PUT: begin
              if ((is_newline || cur_x_r == LAST_COL) && cur_y_r == LAST_ROW) begin
                state_nxt = ST_SCROLL;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            OP_CLEAR: state_nxt = ST_FILL;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCROLL: begin
        if (scan_r == COPY_LEN) begin
          state_nxt = ST_FILL;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // RAM controls. During a scroll the read runs one row and one cell ahead of
  // the write, so a cell is always read before it is overwritten.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_r;
    mem_wdata = SPACE_CHAR;
    mem_re    = 1'b0;
    mem_raddr = cell_addr(in_read_row, in_read_column);
    unique case (state_r)
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        if (in_accept && in_opcode == OP_PUT && !is_newline) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(cur_y_r, cur_x_r);
          mem_wdata = in_char_code;
        end
        if (in_accept && in_opcode == OP_READ && read_in_range) begin
          mem_re = 1'b1;
        end
      end
      ST_SCROLL: begin
        mem_re    = (scan_r != COPY_LEN);
        mem_raddr = ADDR_W'(scan_r + ROW_STEP);
        mem_we    = (scan_r != '0);
        mem_waddr = ADDR_W'(scan_r - ADDR_W'(1));
        mem_wdata = rd_data_r;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Cursor, sweep counter and pending-result bookkeeping.
  always_comb begin
    scan_nxt    = scan_r;
    cur_y_nxt   = cur_y_r;
    cur_x_nxt   = cur_x_r;
    reply_nxt   = reply_r;
    is_read_nxt = is_read_r;
    rd_ok_nxt   = rd_ok_r;
    unique case (state_r)
      ST_FILL: begin
        scan_nxt = ADDR_W'(scan_r + ADDR_W'(1));
      end
      ST_IDLE: begin
        if (in_accept) begin
          reply_nxt   = 1'b1;
          is_read_nxt = 1'b0;
          priority case (in_opcode)
            OP_PUT: begin
              if (is_newline || cur_x_r == LAST_COL) begin
                cur_x_nxt = '0;
                if (cur_y_r == LAST_ROW) begin
                  scan_nxt = '0;
                end else begin
                  cur_y_nxt = ROW_W'(cur_y_r + ROW_W'(1));
                end
              end else begin
                cur_x_nxt = COL_W'(cur_x_r + COL_W'(1));
              end
            end
            OP_CLEAR: begin
              cur_x_nxt = '0;
              cur_y_nxt = '0;
              scan_nxt  = '0;
            end
            OP_READ: begin
              is_read_nxt = 1'b1;
              rd_ok_nxt   = read_in_range;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // The fill of the bottom row starts where the copy stops.
        if (scan_r != COPY_LEN) begin
          scan_nxt = ADDR_W'(scan_r + ADDR_W'(1));
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      scan_r      <= '0;
      cur_y_r     <= '0;
      cur_x_r     <= '0;
      reply_r     <= 1'b0;
      is_read_r   <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      scan_r    <= scan_nxt;
      cur_y_r   <= cur_y_nxt;
      cur_x_r   <= cur_x_nxt;
      reply_r   <= reply_nxt;
      is_read_r <= is_read_nxt;
      rd_ok_r   <= rd_ok_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; the read data register holds until the next RAM read.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cell_r <= (is_read_r && rd_ok_r) ? rd_data_r : '0;
      out_row_r  <= cur_y_r;
      out_col_r  <= cur_x_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_char     = out_cell_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_column = out_col_r;

endmodule

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcs_pkg::*;

  // The one opcode that the package leaves unnamed: it must change nothing.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // A hung block is caught by this many cycles. The slowest correct run is
  // every beat scrolling the screen behind the longest sender gap and receiver
  // stall, and the limit is a few times that.
  localparam int unsigned CYCLE_LIMIT = 10_000_000;

  // Random stimulus is split into phases, each with its own newline density.
  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASE_ITEMS  = 100;

  // Quiet cycles after the last expected result, to catch stray result beats.
  localparam int DRAIN_CYCLES = 50;

  // One result beat as the block shows it.
  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_view_t;

  // One row of the directed table. Where known is set, the expected result
  // is typed in; otherwise it comes from the shadow console below.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              known;
    console_view_t     view;
  } directed_row_t;

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_opcode      = '0;
  logic [CHAR_W-1:0] in_char_code   = '0;
  logic [ROW_W-1:0]  in_read_row    = '0;
  logic [COL_W-1:0]  in_read_column = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [CHAR_W-1:0] out_cell_char;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_column;

  text_console_scroller dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_char_code      (in_char_code),
    .in_read_row       (in_read_row),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_char     (out_cell_char),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the console: the screen bytes and the cursor.
  logic [CHAR_W-1:0] shadow_screen [CELLS];
  int                shadow_row;
  int                shadow_col;

  // Results still owed by the block, oldest first.
  console_view_t     pending_views [$];

  int unsigned       mismatches = 0;
  int unsigned       cycles     = 0;
  int                burst_left = 0;

  // Blank screen with the cursor at home, as after reset or a clear.
  function automatic void blank_console();
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = SPACE_CHAR;
    shadow_row = 0;
    shadow_col = 0;
  endfunction

  // Applies one beat to the shadow console and returns the result it owes.
  function automatic console_view_t console_step(input logic [OP_W-1:0]   op,
                                                 input logic [CHAR_W-1:0] ch,
                                                 input logic [ROW_W-1:0]  rr,
                                                 input logic [COL_W-1:0]  cc);
    console_view_t view;
    view = '0;
    case (op)
      OP_PUT: begin
        // A newline is never stored; it only moves the cursor down.
        if (ch != NEWLINE_CHAR) begin
          shadow_screen[shadow_row * COLUMNS + shadow_col] = ch;
          shadow_col++;
        end else begin
          shadow_col = 0;
          shadow_row++;
        end
        if (shadow_col >= COLUMNS) begin
          shadow_col = 0;
          shadow_row++;
        end
        // Running off the bottom moves every row up one and blanks the last.
        if (shadow_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++)
            shadow_screen[i] = shadow_screen[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++)
            shadow_screen[i] = SPACE_CHAR;
          shadow_row = ROWS - 1;
        end
      end
      OP_CLEAR: blank_console();
      OP_READ: begin
        // Reads outside the screen return zero.
        if (int'(rr) < ROWS && int'(cc) < COLUMNS)
          view.glyph = shadow_screen[int'(rr) * COLUMNS + int'(cc)];
      end
      default: ;
    endcase
    view.row = ROW_W'(shadow_row);
    view.col = COL_W'(shadow_col);
    return view;
  endfunction

  // Drives one beat and waits for it to be taken. The sender works in bursts:
  // when a burst runs out it drops valid for a random gap (possibly none) and
  // starts a new burst of random length. Inputs only change at falling edges.
  task automatic send_beat(input logic [OP_W-1:0]   op,
                           input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0]  rr,
                           input logic [COL_W-1:0]  cc,
                           input logic              known,
                           input console_view_t     known_view);
    int            gap;
    console_view_t predicted;
    if (burst_left == 0) begin
      gap        = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_char_code   <= ch;
    in_read_row    <= rr;
    in_read_column <= cc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // The beat was taken at this edge; the shadow console moves with it.
    predicted = console_step(op, ch, rr, cc);
    pending_views.push_back(known ? known_view : predicted);
  endtask

  // Holds the sender off until the block has delivered every owed result.
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
    burst_left = 0;
  endtask

  // The receiver stalls on a pattern of its own: it switches at random among
  // always ready, coin flips, a fixed one-in-four stall and long stretches of
  // mostly stalling, each mode lasting a random time before the next is picked.
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ((rx_tick % 4) != 3);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result checker: every result beat is held against the oldest owed result.
  always @(posedge clk) begin : result_check
    console_view_t got;
    console_view_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_cell_char, out_cursor_row, out_cursor_column};
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb_top: result beat with nothing owed: cell %02h cursor %0d,%0d",
                   got.glyph, got.row, got.col);
      end else begin
        want = pending_views.pop_front();
        if (got.glyph !== want.glyph || got.row !== want.row || got.col !== want.col) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb_top: mismatch: cell %02h/%02h row %0d/%0d column %0d/%0d (exp/got)",
                     want.glyph, got.glyph, want.row, got.row, want.col, got.col);
        end
      end
    end
  end

  // Watchdog: a hang ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Directed opening. After reset the screen is all spaces and the cursor is
  // home, so the first reads are typed in. Then the screen edges and reads
  // past them, the unused opcode with every field at its top value, both
  // byte extremes, a newline that must not land in the screen, and a clear
  // with stray field values. Fields the operation ignores carry junk.
  directed_row_t directed_rows [0:21] = '{
    '{OP_READ,   8'h00, 5'd0,  7'd0,   1'b1, '{8'h20, 5'd0, 7'd0}},
    '{OP_READ,   8'hff, 5'd24, 7'd79,  1'b1, '{8'h20, 5'd0, 7'd0}},
    '{OP_READ,   8'h00, 5'd31, 7'd127, 1'b1, '{8'h00, 5'd0, 7'd0}},
    '{OP_READ,   8'h00, 5'd25, 7'd0,   1'b1, '{8'h00, 5'd0, 7'd0}},
    '{OP_READ,   8'h00, 5'd0,  7'd80,  1'b1, '{8'h00, 5'd0, 7'd0}},
    '{OP_UNUSED, 8'hff, 5'd31, 7'd127, 1'b1, '{8'h00, 5'd0, 7'd0}},
    '{OP_PUT,    8'h00, 5'd31, 7'd127, 1'b1, '{8'h00, 5'd0, 7'd1}},
    '{OP_PUT,    8'hff, 5'd0,  7'd0,   1'b1, '{8'h00, 5'd0, 7'd2}},
    '{OP_PUT,    8'h0a, 5'd12, 7'd40,  1'b1, '{8'h00, 5'd1, 7'd0}},
    '{OP_READ,   8'hff, 5'd0,  7'd0,   1'b1, '{8'h00, 5'd1, 7'd0}},
    '{OP_READ,   8'h0a, 5'd0,  7'd1,   1'b1, '{8'hff, 5'd1, 7'd0}},
    '{OP_READ,   8'h00, 5'd0,  7'd2,   1'b1, '{8'h20, 5'd1, 7'd0}},
    '{OP_PUT,    8'h41, 5'd1,  7'd0,   1'b1, '{8'h00, 5'd1, 7'd1}},
    '{OP_READ,   8'h00, 5'd1,  7'd0,   1'b1, '{8'h41, 5'd1, 7'd1}},
    '{OP_CLEAR,  8'h41, 5'd5,  7'd5,   1'b1, '{8'h00, 5'd0, 7'd0}},
    '{OP_READ,   8'h00, 5'd1,  7'd0,   1'b1, '{8'h20, 5'd0, 7'd0}},
    '{OP_READ,   8'h00, 5'd0,  7'd1,   1'b1, '{8'h20, 5'd0, 7'd0}},
    '{OP_PUT,    8'h7e, 5'd3,  7'd9,   1'b0, '0},
    '{OP_PUT,    8'h0a, 5'd0,  7'd0,   1'b0, '0},
    '{OP_PUT,    8'h0a, 5'd0,  7'd0,   1'b0, '0},
    '{OP_READ,   8'h00, 5'd0,  7'd0,   1'b0, '0},
    '{OP_UNUSED, 8'h00, 5'd0,  7'd0,   1'b0, '0}
  };

  initial begin
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  cc;
    int unsigned       newline_pct;
    int unsigned       roll;

    blank_console();

    // Synchronous reset held low, then released at a falling edge. The block then runs its own
    // clearing pass; the sender simply waits on in_ready through it.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].row,
                directed_rows[i].col, directed_rows[i].known, directed_rows[i].view);

    // Let the block go fully idle once before the random part.
    wait_until_drained();

    // Random part. Each phase picks a newline density: none at all makes long
    // lines that wrap at the right edge, a light or heavy dose walks the
    // cursor down to the bottom so that most later rows scroll the screen.
    // Clears are kept rare so the cursor spends its time near the bottom.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        case ($urandom_range(0, 3))
          0:       newline_pct = 0;
          1:       newline_pct = 10;
          default: newline_pct = 30;
        endcase
        // Every fourth phase the sender waits for the block to empty.
        if (n != 0 && (n / PHASE_ITEMS) % 4 == 0) wait_until_drained();
      end
      roll = $urandom_range(0, 999);
      ch   = 8'($urandom_range(0, 255));
      rr   = 5'($urandom_range(0, 31));
      cc   = 7'($urandom_range(0, 127));
      if (roll < 3) begin
        op = OP_CLEAR;
      end else if (roll < 25) begin
        op = OP_UNUSED;
      end else if (roll < 300) begin
        op = OP_READ;
        // Most reads land on the screen; the rest use the whole field range.
        if ($urandom_range(0, 99) < 85) begin
          rr = ROW_W'($urandom_range(0, ROWS - 1));
          cc = COL_W'($urandom_range(0, COLUMNS - 1));
        end
      end else begin
        op = OP_PUT;
        if ($urandom_range(0, 99) < newline_pct) ch = NEWLINE_CHAR;
      end
      send_beat(op, ch, rr, cc, 1'b0, '0);
    end

    // Drop valid, wait for the last owed result, then watch a while longer
    // for anything the block should not have sent.
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tcs_pkg.sv
rtl/text_console_scroller.sv
dv/tb_top.sv
